FILE: sv/smbbm_pkg.sv
// Types, codes and constants shared by the switch matrix controller.
package smbbm_pkg;

  localparam int FRAME_W = 40;

  typedef enum logic [2:0] {
    MODE_INIT      = 3'd0,
    MODE_SET_RAW   = 3'd1,
    MODE_SET_SAFE  = 3'd2,
    MODE_SET_SW    = 3'd3,
    MODE_SET_ST    = 3'd4,
    MODE_RESET_ALL = 3'd5,
    MODE_SOFT_RST  = 3'd6
  } mode_t;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOINIT  = 3'd1;
  localparam logic [2:0] ST_BADIDX  = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_SAME    = 3'd4;

  localparam logic [2:0] CFG_IL_DEV  = 3'd0;
  localparam logic [2:0] CFG_IL_MASK = 3'd1;
  localparam logic [2:0] CFG_ST_EN   = 3'd2;
  localparam logic [2:0] CFG_GRP_A   = 3'd3;
  localparam logic [2:0] CFG_GRP_B   = 3'd4;
  localparam logic [2:0] CFG_GRP_C   = 3'd5;

  // address-mode command words
  localparam logic [7:0]  CMD_WRITE      = 8'h00;
  localparam logic [7:0]  REG_FIELD      = 8'h7F;
  localparam logic [7:0]  REG_SOFT_RESET = 8'h0B;
  localparam logic [7:0]  SOFT_KEY1      = 8'hA3;
  localparam logic [7:0]  SOFT_KEY2      = 8'h05;
  localparam logic [15:0] DAISY_WORD     = 16'h2500;
  localparam logic [15:0] SOFT_WORD1 = {CMD_WRITE | (REG_SOFT_RESET & REG_FIELD), SOFT_KEY1};
  localparam logic [15:0] SOFT_WORD2 = {CMD_WRITE | (REG_SOFT_RESET & REG_FIELD), SOFT_KEY2};

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  device;
    logic [3:0]  switch_index;
    logic        closed;
    logic [31:0] all_states;
    logic [7:0]  selftest_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FRAME_W-1:0] frame_data;
    logic               dead_time_after;
    logic [2:0]         status;
    logic               selftest_active;
    logic [7:0]         device_state;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] il_dev;
    logic [7:0] il_mask;
    logic       st_en;
    logic [7:0] grp_a;
    logic [7:0] grp_b;
    logic [7:0] grp_c;
  } cfg_t;

  // results of one request, loaded into the result buffer at once
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } res_pair_t;

endpackage

FILE: sv/smbbm_core.sv
// Request decode, break-before-make frame build and next device state.
module smbbm_core import smbbm_pkg::*; #(
  parameter int MAIN_DEVICES = 4
) (
  input  in_item_t                       item,
  input  cfg_t                           cfg,
  input  logic [MAIN_DEVICES-1:0][7:0]   main_cur,
  input  logic [7:0]                     st_cur,
  input  logic                           rdy_cur,
  output logic [MAIN_DEVICES-1:0][7:0]   main_nxt,
  output logic [7:0]                     st_nxt,
  output logic                           rdy_nxt,
  output res_pair_t                      res
);

  function automatic logic [FRAME_W-1:0] frame_of(
    input logic [MAIN_DEVICES-1:0][7:0] mb,
    input logic [7:0]                   sb,
    input logic                         st_en
  );
    logic [63:0]        mbx;
    logic [FRAME_W-1:0] f;
    mbx = 64'(mb);
    f   = '0;
    for (int i = 0; i < 5; i++) begin
      if (i < MAIN_DEVICES) begin
        f[8*i +: 8] = mbx[8*i +: 8];
      end else if (i == MAIN_DEVICES && st_en) begin
        f[8*i +: 8] = sb;
      end
    end
    return f;
  endfunction

  logic [63:0]                    all_ext;
  logic [MAIN_DEVICES-1:0][7:0]   req;
  logic [MAIN_DEVICES-1:0][7:0]   tmp;
  logic [MAIN_DEVICES-1:0][7:0]   zero_b;
  logic                           il_req;
  logic                           il_cur;
  logic                           dev_ok;
  logic [7:0]                     dev_byte;
  logic [7:0]                     bit_sel;
  logic [7:0]                     grp;
  logic                           st_on;
  logic [2:0]                     status;
  logic                           two;
  logic [1:0]                     k0, k1;
  logic [FRAME_W-1:0]             d0, d1;
  logic                           dt0;
  logic [7:0]                     dstate;

  always_comb begin
    all_ext = 64'(item.all_states);
    zero_b  = '0;
    il_req  = 1'b0;
    il_cur  = 1'b0;
    dev_byte = '0;
    for (int i = 0; i < MAIN_DEVICES; i++) begin
      req[i] = all_ext[8*i +: 8];
      if (32'(cfg.il_dev) == i) begin
        il_req = (all_ext[8*i +: 8] & cfg.il_mask) != 8'd0;
        il_cur = (main_cur[i] & cfg.il_mask) != 8'd0;
      end
      if (32'(item.device) == i) dev_byte = main_cur[i];
    end
    dev_ok  = 32'(item.device) < MAIN_DEVICES;
    bit_sel = 8'(8'd1 << item.switch_index[2:0]);
    if (item.switch_index < 4'd4)      grp = cfg.grp_a;
    else if (item.switch_index < 4'd6) grp = cfg.grp_b;
    else                               grp = cfg.grp_c;
    st_on = st_cur != 8'd0;

    main_nxt = main_cur;
    st_nxt   = st_cur;
    rdy_nxt  = rdy_cur;
    tmp      = main_cur;
    status   = ST_OK;
    two      = 1'b0;
    k0       = KIND_STATUS;
    k1       = KIND_STATUS;
    d0       = '0;
    d1       = '0;
    dt0      = 1'b0;

    case (item.mode)
      MODE_INIT: begin
        main_nxt = '0;
        st_nxt   = '0;
        rdy_nxt  = 1'b1;
        two      = 1'b1;
        k0       = KIND_WORD;
        d0       = FRAME_W'(DAISY_WORD);
        k1       = KIND_FRAME;
        d1       = '0;
      end
      MODE_SET_RAW: begin
        if (!rdy_cur) begin
          status = ST_NOINIT;
        end else begin
          main_nxt = req;
          k0       = KIND_FRAME;
          d0       = frame_of(req, st_cur, cfg.st_en);
        end
      end
      MODE_SET_SAFE: begin
        if (!rdy_cur) begin
          status = ST_NOINIT;
        end else if (cfg.st_en && il_req && st_on) begin
          status = ST_BLOCKED;
        end else begin
          main_nxt = req;
          two      = 1'b1;
          k0       = KIND_FRAME;
          d0       = frame_of(zero_b, st_cur, cfg.st_en);
          dt0      = 1'b1;
          k1       = KIND_FRAME;
          d1       = frame_of(req, st_cur, cfg.st_en);
        end
      end
      MODE_SET_SW: begin
        if (!dev_ok || item.switch_index[3]) begin
          status = ST_BADIDX;
        end else if (!rdy_cur) begin
          status = ST_NOINIT;
        end else if (cfg.st_en && item.device == {1'b0, cfg.il_dev} && item.closed &&
                     (bit_sel & cfg.il_mask) != 8'd0 && st_on) begin
          status = ST_BLOCKED;
        end else begin
          for (int i = 0; i < MAIN_DEVICES; i++) begin
            if (32'(item.device) == i) begin
              tmp[i] = dev_byte & ~grp;
              if (item.closed) main_nxt[i] = (dev_byte & ~grp) | bit_sel;
              else             main_nxt[i] = dev_byte & ~bit_sel;
            end
          end
          k0 = KIND_FRAME;
          if (item.closed) begin
            two = 1'b1;
            d0  = frame_of(tmp, st_cur, cfg.st_en);
            dt0 = 1'b1;
            k1  = KIND_FRAME;
            d1  = frame_of(main_nxt, st_cur, cfg.st_en);
          end else begin
            d0  = frame_of(main_nxt, st_cur, cfg.st_en);
          end
        end
      end
      MODE_SET_ST: begin
        if (!cfg.st_en) begin
          status = ST_BADIDX;
        end else if (!rdy_cur) begin
          status = ST_NOINIT;
        end else if (item.selftest_byte != 8'd0 && il_cur) begin
          status = ST_BLOCKED;
        end else if (st_cur == item.selftest_byte) begin
          status = ST_SAME;
        end else begin
          // self-test device opens first, then takes the new byte
          st_nxt = item.selftest_byte;
          k0     = KIND_FRAME;
          d0     = frame_of(main_cur, 8'd0, cfg.st_en);
          if (item.selftest_byte != 8'd0) begin
            two = 1'b1;
            dt0 = 1'b1;
            k1  = KIND_FRAME;
            d1  = frame_of(main_cur, item.selftest_byte, cfg.st_en);
          end
        end
      end
      MODE_RESET_ALL: begin
        main_nxt = '0;
        st_nxt   = '0;
        if (rdy_cur) begin
          k0 = KIND_FRAME;
          d0 = '0;
        end else begin
          status = ST_NOINIT;
        end
      end
      MODE_SOFT_RST: begin
        main_nxt = '0;
        st_nxt   = '0;
        rdy_nxt  = 1'b0;
        two      = 1'b1;
        k0       = KIND_WORD;
        d0       = FRAME_W'(SOFT_WORD1);
        k1       = KIND_WORD;
        d1       = FRAME_W'(SOFT_WORD2);
      end
      default: begin
        status = ST_BADIDX;
      end
    endcase

    dstate = '0;
    if (item.mode == MODE_SET_ST) begin
      dstate = st_nxt;
    end else begin
      for (int i = 0; i < MAIN_DEVICES; i++) begin
        if (32'(item.device) == i) dstate = main_nxt[i];
      end
    end

    res.two                   = two;
    res.r0.kind               = k0;
    res.r0.frame_data         = d0;
    res.r0.dead_time_after    = dt0;
    res.r0.status             = status;
    res.r0.selftest_active    = st_nxt != 8'd0;
    res.r0.device_state       = dstate;
    res.r0.last               = !two;
    res.r1.kind               = k1;
    res.r1.frame_data         = d1;
    res.r1.dead_time_after    = 1'b0;
    res.r1.status             = status;
    res.r1.selftest_active    = st_nxt != 8'd0;
    res.r1.device_state       = dstate;
    res.r1.last               = 1'b1;
  end

endmodule

FILE: sv/smbbm_resq.sv
// Two-slot result buffer; drains one result per cycle while out_ready is high.
module smbbm_resq import smbbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_pair_t res,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  slot0_r, slot1_r;
  logic [1:0] cnt_r;

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot0_r;
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= res.two ? 2'd2 : 2'd1;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= res.r0;
      slot1_r <= res.r1;
    end else if (out_valid && out_ready) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

FILE: sv/switch_matrix_break_before_make.sv
// Top level of the break-before-make switch matrix controller.
// Each request enters an input register, is decoded in one pass against the
// held device bytes and lands in a two-slot result buffer, from which results
// leave one per cycle while out_ready is high (a request yields one or two). The
// first result of a request passes the input register and then the result buffer
// before it is visible; a request is decoded as soon as the buffer is empty or its
// last result is being taken, so the buffer takes a new request while the last
// result of the one before it leaves, and a stream of requests is paced by the
// single output port of the result buffer. Configuration writes take effect on
// the next cycle and must be issued only while no request is in flight. Frames
// carry device i in bits 8i+7:8i (highest device on top), with the self-test byte
// appended when it is enabled.
module switch_matrix_break_before_make import smbbm_pkg::*; #(
  parameter int MAIN_DEVICES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  in_item_t                      item_r;
  logic                          item_vld_r;
  cfg_t                          cfg_r;
  logic [MAIN_DEVICES-1:0][7:0]  main_r;
  logic [7:0]                    st_r;
  logic                          rdy_r;

  logic [MAIN_DEVICES-1:0][7:0]  main_nxt;
  logic [7:0]                    st_nxt;
  logic                          rdy_nxt;
  res_pair_t                     res;
  logic                          can_load;
  logic                          proc;

  // request is decoded once the result buffer has room for its results
  assign proc     = item_vld_r && can_load;
  assign in_ready = !item_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_vld_r <= 1'b1;
    end else if (proc) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.il_dev  <= 2'd3;
      cfg_r.il_mask <= 8'd2;
      cfg_r.st_en   <= 1'b1;
      cfg_r.grp_a   <= 8'd15;
      cfg_r.grp_b   <= 8'd48;
      cfg_r.grp_c   <= 8'd192;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IL_DEV:  cfg_r.il_dev  <= cfg_wdata[1:0];
        CFG_IL_MASK: cfg_r.il_mask <= cfg_wdata;
        CFG_ST_EN:   cfg_r.st_en   <= cfg_wdata[0];
        CFG_GRP_A:   cfg_r.grp_a   <= cfg_wdata;
        CFG_GRP_B:   cfg_r.grp_b   <= cfg_wdata;
        CFG_GRP_C:   cfg_r.grp_c   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // device bytes and chain-ready flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r <= '0;
      st_r   <= '0;
      rdy_r  <= 1'b0;
    end else if (proc) begin
      main_r <= main_nxt;
      st_r   <= st_nxt;
      rdy_r  <= rdy_nxt;
    end
  end

  smbbm_core #(
    .MAIN_DEVICES (MAIN_DEVICES)
  ) u_core (
    .item     (item_r),
    .cfg      (cfg_r),
    .main_cur (main_r),
    .st_cur   (st_r),
    .rdy_cur  (rdy_r),
    .main_nxt (main_nxt),
    .st_nxt   (st_nxt),
    .rdy_nxt  (rdy_nxt),
    .res      (res)
  );

  smbbm_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a decoded request always shows a result on the next cycle
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_valid)
    else $error("no result after request decode");

  // soft reset leaves the chain uninitialized with all switches open
  a_soft_rst: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item_r.mode == MODE_SOFT_RST |=> !rdy_r && st_r == 8'd0 && main_r == '0)
    else $error("soft reset left state behind");

  // init marks the chain ready with all switches open
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item_r.mode == MODE_INIT |=> rdy_r && st_r == 8'd0 && main_r == '0)
    else $error("init did not set up the chain");

endmodule
